@@ rtl/mfhc_pkg.sv @@
// Shared types and constants for the multiplex frame header checker.
// Used by mfhc_classify and mux_frame_header_check; no dependencies.
`default_nettype none

package mfhc_pkg;

  localparam int unsigned ID_LENGTH   = 16;
  localparam int unsigned HEADER_SIZE = ID_LENGTH + 5;
  localparam int unsigned POS_W       = $clog2(HEADER_SIZE + 1);

  localparam logic [31:0] DISC_TYPE_RESET = 32'd2;

  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [1:0] {
    ROLE_ID      = 2'd0,
    ROLE_TERM    = 2'd1,
    ROLE_TYPE    = 2'd2,
    ROLE_PAYLOAD = 2'd3
  } role_t;

  typedef enum logic [2:0] {
    STATUS_OK           = 3'd0,
    STATUS_TRUNCATED    = 3'd1,
    STATUS_NO_TERM      = 3'd2,
    STATUS_BAD_ID       = 3'd3,
    STATUS_UNKNOWN_TYPE = 3'd4,
    STATUS_DISC_PAYLOAD = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_last;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  byte_role;
    logic [7:0]  byte_out;
    logic        frame_end;
    logic [2:0]  status;
    logic [31:0] packet_type;
  } out_beat_t;

  typedef struct packed {
    pos_t        pos;
    logic        id_invalid;
    logic        term_bad;
    logic [31:0] type_acc;
    logic        payload_seen;
  } frame_state_t;

endpackage

`default_nettype wire

@@ rtl/mux_frame_header_check.sv @@
// Top level of the multiplex frame header checker: input register, classifier,
// result register and the disconnect type register. Depends on mfhc_pkg, mfhc_classify.
`default_nettype none

// Takes one frame byte per beat and returns one result beat per byte, with the
// byte's role and, on the beat marked last, the frame status and decoded type.
// Takes one byte per cycle while the output is not stalled; each byte passes through
// the input register, the classifier and the result register to the result.
// Both registers can hold a beat, so input is taken while a result waits until the input register is full.
// Write cfg_wr_data with cfg_wr_en only while no beat is in flight.
module mux_frame_header_check (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfhc_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_ready,
  output mfhc_pkg::out_beat_t out_beat,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data
);
  import mfhc_pkg::*;

  logic         in_valid_r;
  in_beat_t     in_beat_r;
  logic         out_valid_r;
  out_beat_t    out_beat_r;
  frame_state_t state_r;
  frame_state_t state_nxt;
  out_beat_t    result;
  logic [31:0]  disc_type_r;
  logic         advance;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  mfhc_classify u_classify (
    .beat      (in_beat_r),
    .state     (state_r),
    .disc_type (disc_type_r),
    .result    (result),
    .state_nxt (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
      disc_type_r <= DISC_TYPE_RESET;
    end else begin
      if (cfg_wr_en) begin
        disc_type_r <= cfg_wr_data;
      end
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_beat_r <= in_beat;
    end
    if (advance && in_valid_r) begin
      out_beat_r <= result;
    end
  end

  a_full_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while both stages are full and stalled");

  a_frame_close_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_valid_r && in_beat_r.frame_last) |=> (state_r == '0))
    else $error("frame state not cleared after the last beat");

  a_mid_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_beat_r.frame_end) |->
      (out_beat_r.status == STATUS_OK && out_beat_r.packet_type == 32'd0))
    else $error("status or type reported before frame end");

  a_truncated_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.frame_end && out_beat_r.status == STATUS_TRUNCATED) |->
      (out_beat_r.packet_type == 32'd0 && out_beat_r.byte_role != ROLE_PAYLOAD))
    else $error("truncated frame reports a type or payload");

endmodule

`default_nettype wire

@@ rtl/mfhc_classify.sv @@
// Per-beat classification: byte role, frame state update and end-of-frame status.
// Purely combinational; depends on mfhc_pkg.
`default_nettype none

module mfhc_classify (
  input  mfhc_pkg::in_beat_t     beat,
  input  mfhc_pkg::frame_state_t state,
  input  logic [31:0]            disc_type,
  output mfhc_pkg::out_beat_t    result,
  output mfhc_pkg::frame_state_t state_nxt
);
  import mfhc_pkg::*;

  function automatic logic id_char_ok(input logic [7:0] c);
    id_char_ok = (c >= 8'h30 && c <= 8'h39) ||
                 (c >= 8'h41 && c <= 8'h5a) ||
                 (c >= 8'h61 && c <= 8'h7a);
  endfunction

  localparam pos_t ID_POS   = pos_t'(ID_LENGTH);
  localparam pos_t HDR_POS  = pos_t'(HEADER_SIZE);
  localparam pos_t TYPE_POS = pos_t'(ID_LENGTH + 1);

  role_t       role;
  frame_state_t upd;
  logic [1:0]  type_off;
  logic [31:0] shifted;
  status_t     status;

  assign type_off = state.pos[1:0] - TYPE_POS[1:0];

  always_comb begin
    case (type_off)
      2'd0:    shifted = {24'd0, beat.data_byte};
      2'd1:    shifted = {16'd0, beat.data_byte, 8'd0};
      2'd2:    shifted = {8'd0, beat.data_byte, 16'd0};
      default: shifted = {beat.data_byte, 24'd0};
    endcase
  end

  always_comb begin
    upd = state;
    if (state.pos < ID_POS) begin
      role = ROLE_ID;
      if (!id_char_ok(beat.data_byte)) begin
        upd.id_invalid = 1'b1;
      end
    end else if (state.pos == ID_POS) begin
      role = ROLE_TERM;
      upd.term_bad = (beat.data_byte != 8'd0);
    end else if (state.pos < HDR_POS) begin
      role = ROLE_TYPE;
      upd.type_acc = state.type_acc | shifted;
    end else begin
      role = ROLE_PAYLOAD;
      upd.payload_seen = 1'b1;
    end
    if (state.pos < HDR_POS) begin
      upd.pos = state.pos + pos_t'(1);
    end
  end

  always_comb begin
    if (upd.pos < HDR_POS) begin
      status = STATUS_TRUNCATED;
    end else if (upd.term_bad) begin
      status = STATUS_NO_TERM;
    end else if (upd.id_invalid) begin
      status = STATUS_BAD_ID;
    end else if (upd.type_acc > disc_type) begin
      status = STATUS_UNKNOWN_TYPE;
    end else if (upd.type_acc == disc_type && upd.payload_seen) begin
      status = STATUS_DISC_PAYLOAD;
    end else begin
      status = STATUS_OK;
    end
  end

  always_comb begin
    result.byte_role   = role;
    result.byte_out    = beat.data_byte;
    result.frame_end   = beat.frame_last;
    result.status      = STATUS_OK;
    result.packet_type = 32'd0;
    state_nxt          = upd;
    if (beat.frame_last) begin
      result.status = status;
      if (upd.pos >= HDR_POS) begin
        result.packet_type = upd.type_acc;
      end
      state_nxt = '0;
    end
  end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench for mux_frame_header_check: a directed frame table, then random frames
// under several disconnect type settings and idle patterns, checked beat by beat.
// Depends on mfhc_pkg and the mux_frame_header_check RTL.
`timescale 1ns / 1ps

module tb_top;
  import mfhc_pkg::*;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        typed;
    role_t       role;
    status_t     status;
    logic [31:0] ptype;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 24;
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_BEATS = 290;

  // Rows with typed set carry their own expectation; the rest go through the predictor.
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{8'hFF, 1'b1, 1'b1, ROLE_ID,      STATUS_TRUNCATED,    32'd0},
    '{8'h00, 1'b1, 1'b1, ROLE_ID,      STATUS_TRUNCATED,    32'd0},
    '{"0",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"9",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"A",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"Z",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"a",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"z",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"M",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"q",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"5",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"b",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"Y",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"1",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"8",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"k",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"T",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{"7",   1'b0, 1'b0, ROLE_ID,      STATUS_OK,           32'd0},
    '{8'h00, 1'b0, 1'b0, ROLE_TERM,    STATUS_OK,           32'd0},
    '{8'h02, 1'b0, 1'b0, ROLE_TYPE,    STATUS_OK,           32'd0},
    '{8'h00, 1'b0, 1'b0, ROLE_TYPE,    STATUS_OK,           32'd0},
    '{8'h00, 1'b0, 1'b0, ROLE_TYPE,    STATUS_OK,           32'd0},
    '{8'h00, 1'b0, 1'b0, ROLE_TYPE,    STATUS_OK,           32'd0},
    '{8'h80, 1'b1, 1'b1, ROLE_PAYLOAD, STATUS_DISC_PAYLOAD, 32'd2}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_beat_t    in_beat;
  logic        out_valid;
  logic        out_ready;
  out_beat_t   out_beat;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned err_count;

  // Predictor state for the frame in progress.
  pos_t        hdr_pos;
  logic        id_bad;
  logic        term_nonzero;
  logic [31:0] type_acc;
  logic        body_seen;
  logic [31:0] disc_code;

  out_beat_t   frame_results_q [$];
  logic [7:0]  frame_bytes [$];

  mux_frame_header_check u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_beat     (in_beat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_beat    (out_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[mux_frame_header_check] ERROR");
    $finish;
  end

  function automatic logic is_id_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic out_beat_t classify_byte(input in_beat_t b);
    pos_t      pos;
    out_beat_t r;
    r = '0;
    r.byte_out = b.data_byte;
    r.frame_end = b.frame_last;
    pos = hdr_pos;
    if (pos < ID_LENGTH) begin
      r.byte_role = ROLE_ID;
      if (!is_id_char(b.data_byte)) id_bad = 1'b1;
    end else if (pos == ID_LENGTH) begin
      r.byte_role = ROLE_TERM;
      term_nonzero = (b.data_byte != 8'h00);
    end else if (pos < HEADER_SIZE) begin
      r.byte_role = ROLE_TYPE;
      type_acc = type_acc | (32'(b.data_byte) << (8 * (pos - ID_LENGTH - 1)));
    end else begin
      r.byte_role = ROLE_PAYLOAD;
      body_seen = 1'b1;
    end
    if (hdr_pos < HEADER_SIZE) hdr_pos = pos + 1'b1;
    if (b.frame_last) begin
      if (hdr_pos < HEADER_SIZE) begin
        r.status = STATUS_TRUNCATED;
      end else begin
        r.packet_type = type_acc;
        if (term_nonzero) r.status = STATUS_NO_TERM;
        else if (id_bad) r.status = STATUS_BAD_ID;
        else if (type_acc > disc_code) r.status = STATUS_UNKNOWN_TYPE;
        else if (type_acc == disc_code && body_seen) r.status = STATUS_DISC_PAYLOAD;
        else r.status = STATUS_OK;
      end
      hdr_pos = '0;
      id_bad = 1'b0;
      term_nonzero = 1'b0;
      type_acc = '0;
      body_seen = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    out_beat_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected, byte %h", out_beat.byte_out));
      end else begin
        exp_r = frame_results_q.pop_front();
        if (out_beat.byte_role !== exp_r.byte_role)
          report_mismatch($sformatf("byte_role %0d, expected %0d",
                                    out_beat.byte_role, exp_r.byte_role));
        if (out_beat.byte_out !== exp_r.byte_out)
          report_mismatch($sformatf("byte_out %h, expected %h",
                                    out_beat.byte_out, exp_r.byte_out));
        if (out_beat.frame_end !== exp_r.frame_end)
          report_mismatch($sformatf("frame_end %b, expected %b",
                                    out_beat.frame_end, exp_r.frame_end));
        if (out_beat.status !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d",
                                    out_beat.status, exp_r.status));
        if (out_beat.packet_type !== exp_r.packet_type)
          report_mismatch($sformatf("packet_type %h, expected %h",
                                    out_beat.packet_type, exp_r.packet_type));
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_disconnect_type(input logic [31:0] value);
    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    disc_code = value;
  endtask

  function automatic logic [7:0] random_id_char();
    int unsigned r;
    r = $urandom_range(61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    return 8'("a" + r - 36);
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (is_id_char(c)) c = 8'($urandom_range(255));
    return c;
  endfunction

  // Full-header frames, some with bad ID, terminator or type; rest truncated or noise.
  task automatic build_frame();
    int unsigned kind;
    int unsigned body_len;
    int unsigned n;
    logic [31:0] ptype;
    frame_bytes.delete();
    kind = $urandom_range(9);
    if (kind == 0) begin
      n = $urandom_range(HEADER_SIZE - 1, 1);
      repeat (n) frame_bytes.push_back(($urandom_range(3) == 0) ? random_bad_char()
                                                              : random_id_char());
      return;
    end
    if (kind == 1) begin
      n = $urandom_range(30, 1);
      repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    repeat (ID_LENGTH) frame_bytes.push_back(random_id_char());
    if (kind == 2) begin
      n = $urandom_range(3, 1);
      repeat (n) frame_bytes[$urandom_range(ID_LENGTH - 1)] = random_bad_char();
    end
    if (kind == 3 || (kind == 2 && $urandom_range(2) == 0))
      frame_bytes.push_back(8'($urandom_range(255, 1)));
    else
      frame_bytes.push_back(8'h00);
    case (kind)
      4: ptype = (disc_code == 32'hFFFF_FFFF) ? $urandom
                                              : $urandom_range(32'hFFFF_FFFF, disc_code + 1);
      5, 6: ptype = disc_code;
      default: ptype = ($urandom_range(3) == 0) ? $urandom : $urandom_range(disc_code, 0);
    endcase
    for (int i = 0; i < 4; i++) frame_bytes.push_back(ptype[8*i +: 8]);
    if ($urandom_range(9) == 0) body_len = $urandom_range(40, 5);
    else body_len = $urandom_range(4, 0);
    if (kind == 5 && body_len == 0) body_len = 1;
    if (kind == 6) body_len = 0;
    repeat (body_len) frame_bytes.push_back(8'($urandom_range(255)));
  endtask

  initial begin
    in_beat_t    b;
    out_beat_t   e;
    int unsigned phase_beats;
    logic [31:0] setting;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_beat <= '0;
    out_ready <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    send_idle_pct = 27;
    recv_idle_pct = 57;
    err_count = 0;
    hdr_pos = '0;
    id_bad = 1'b0;
    term_nonzero = 1'b0;
    type_acc = '0;
    body_seen = 1'b0;
    disc_code = DISC_TYPE_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      b.data_byte = DIR_TABLE[i].data;
      b.frame_last = DIR_TABLE[i].last;
      send_beat(b);
      e = classify_byte(b);
      if (DIR_TABLE[i].typed) begin
        e.byte_role = DIR_TABLE[i].role;
        e.byte_out = DIR_TABLE[i].data;
        e.frame_end = DIR_TABLE[i].last;
        e.status = DIR_TABLE[i].status;
        e.packet_type = DIR_TABLE[i].ptype;
      end
      frame_results_q.push_back(e);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = 32'h0000_0000;
        1: setting = 32'hFFFF_FFFF;
        2: setting = $urandom;
        3: setting = 32'd7;
        4: setting = $urandom_range(255);
        default: setting = DISC_TYPE_RESET;
      endcase
      write_disconnect_type(setting);
      case (p / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_beats = 0;
      while (phase_beats < PHASE_BEATS) begin
        build_frame();
        foreach (frame_bytes[i]) begin
          b.data_byte = frame_bytes[i];
          b.frame_last = (i == frame_bytes.size() - 1);
          send_beat(b);
          frame_results_q.push_back(classify_byte(b));
          phase_beats++;
        end
      end
    end

    in_valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("[mux_frame_header_check] OK");
    end else begin
      $display("[mux_frame_header_check] ERROR");
    end
    $finish;
  end

endmodule
